FILE: design/lfpid_pkg.sv
package lfpid_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 10;
    localparam int DUTY_W   = 8;
    localparam int TIME_W   = 16;
    localparam int ERR_W    = 11;
    localparam int INTEG_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KD      = 3'd1,
        REG_KI      = 3'd2,
        REG_THR     = 3'd3,
        REG_MAX     = 3'd4,
        REG_BIAS    = 3'd5,
        REG_STARTUP = 3'd6,
        REG_NONE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  kd;
        logic [GAIN_W-1:0]  ki;
        logic [THR_W-1:0]   thr;
        logic [DUTY_W-1:0]  max_duty;
        logic [DUTY_W-1:0]  bias;
        logic [TIME_W-1:0]  startup;
    } cfg_t;

endpackage

FILE: design/lfpid_lane.sv
module lfpid_lane
    import lfpid_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int INDEX_W     = 4,
    parameter int INDEX       = 0
) (
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  logic [THR_W-1:0]               thr,
    output logic [SAMPLE_BITS-1:0]         value,
    output logic [SAMPLE_BITS+INDEX_W-1:0] weighted
);
    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

    logic [CMP_W-1:0] thr_ext;
    logic [CMP_W-1:0] samp_ext;

    assign thr_ext  = CMP_W'(thr);
    assign samp_ext = CMP_W'(sample);
    assign value    = (samp_ext < thr_ext) ? '0 : sample;
    assign weighted = (SAMPLE_BITS+INDEX_W)'(value) * (SAMPLE_BITS+INDEX_W)'(INDEX);
endmodule

FILE: design/lfpid_div.sv
module lfpid_div
    import lfpid_pkg::*;
#(
    parameter int W = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

FILE: design/line_follow_pid_drive_unit.sv
// One item at a time. A tracked item makes two passes through one shared 48-bit
// radix-2 divider (position, derivative) and a three-step reciprocal multiply for
// the integral term; a cross line or a lost line skips them and goes to the output.
// Input ready is high whenever no item is in work; a waiting result holds the next
// item in its last step.
// Reset (synchronous, aresetn low) clears loop state, duties and run time, and
// sets the configuration registers to their defaults.
module line_follow_pid_drive_unit
    import lfpid_pkg::*;
#(
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_0,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_1,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_2,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_3,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_4,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_5,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_6,
    input  logic [SAMPLE_BITS-1:0]              s_sensor_7,
    input  logic [TIME_W-1:0]                   s_elapsed_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [DUTY_W-1:0]                   m_left_duty,
    output logic [DUTY_W-1:0]                   m_right_duty,
    output logic signed [ERR_W-1:0]             m_position_error,
    output logic                                m_crossing,
    output logic                                m_line_lost
);
    localparam int IDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SUMV_W = SAMPLE_BITS + IDX_W + 1;
    localparam int SUMW_W = SAMPLE_BITS + 2 * IDX_W + 1;
    localparam int DIV_W  = 48;
    localparam int U_W    = 52;
    localparam int ACC_W  = 96;
    localparam int RECIP_SHIFT = 57;
    localparam logic [47:0] RECIP_1000 = 48'h8312_6E97_8D50;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_POS_GO, ST_POS_WAIT, ST_D_GO, ST_D_WAIT,
        ST_I_GO, ST_I_WAIT, ST_MIX, ST_OUT
    } state_t;

    cfg_t   cfg_reg;
    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp       <= 16'd32000;
            cfg_reg.kd       <= 16'd3584;
            cfg_reg.ki       <= 16'd0;
            cfg_reg.thr      <= 10'd512;
            cfg_reg.max_duty <= 8'd255;
            cfg_reg.bias     <= 8'd20;
            cfg_reg.startup  <= 16'd1000;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:      cfg_reg.kp       <= cfg_data;
                REG_KD:      cfg_reg.kd       <= cfg_data;
                REG_KI:      cfg_reg.ki       <= cfg_data;
                REG_THR:     cfg_reg.thr      <= cfg_data[THR_W-1:0];
                REG_MAX:     cfg_reg.max_duty <= cfg_data[DUTY_W-1:0];
                REG_BIAS:    cfg_reg.bias     <= cfg_data[DUTY_W-1:0];
                REG_STARTUP: cfg_reg.startup  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0]         in_reg;
    logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0]         lane_v;
    logic [SENSOR_COUNT-1:0][SAMPLE_BITS+IDX_W-1:0]   lane_w;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lfpid_lane #(
            .SAMPLE_BITS(SAMPLE_BITS), .INDEX_W(IDX_W), .INDEX(g)
        ) u_lane (
            .sample(in_reg[g]), .thr(cfg_reg.thr),
            .value(lane_v[g]), .weighted(lane_w[g])
        );
    end

    logic [SUMV_W-1:0] sumv_c;
    logic [SUMW_W-1:0] sumw_c;
    always_comb begin
        sumv_c = '0;
        sumw_c = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sumv_c = sumv_c + SUMV_W'(lane_v[i]);
            sumw_c = sumw_c + SUMW_W'(lane_w[i]);
        end
    end

    logic [TIME_W-1:0]        el_reg;
    logic [TIME_W-1:0]        run_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic                     known_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIV_W-1:0]  d_reg;
    logic signed [DIV_W-1:0]  i_reg;
    logic signed [DIV_W-1:0]  p_reg;
    logic                     dneg_reg;
    logic [DUTY_W-1:0]        left_reg;
    logic [DUTY_W-1:0]        right_reg;
    logic                     cross_reg;
    logic                     lost_reg;
    logic                     m_valid_reg;
    logic [DUTY_W-1:0]        out_left_reg;
    logic [DUTY_W-1:0]        out_right_reg;
    logic signed [ERR_W-1:0]  out_err_reg;
    logic                     out_cross_reg;
    logic                     out_lost_reg;
    logic [DIV_W-1:0]         ix_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [1:0]               step_reg;

    logic             div_start;
    logic [DIV_W-1:0] div_a;
    logic [DIV_W-1:0] div_b;
    logic [DIV_W-1:0] div_q;
    logic             div_done;
    logic [DIV_W-1:0] div_a_reg;
    logic [DIV_W-1:0] div_b_reg;
    logic [DIV_W-1:0] d_num_c;
    logic             out_load;

    lfpid_div #(.W(DIV_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .quotient(div_q), .done(div_done)
    );

    assign div_start = (state_reg == ST_POS_GO) || (state_reg == ST_D_GO);
    assign div_a = (state_reg == ST_D_GO) ? d_num_c : div_a_reg;
    assign div_b = (state_reg == ST_D_GO) ? DIV_W'(el_reg) : div_b_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    logic [TIME_W:0]   run_sum;
    logic [TIME_W-1:0] run_sat;
    logic [SUMV_W+THR_W-1:0] cross_lim;
    assign run_sum   = {1'b0, run_reg} + {1'b0, el_reg};
    assign run_sat   = run_sum[TIME_W] ? '1 : run_sum[TIME_W-1:0];
    assign cross_lim = (SUMV_W+THR_W)'(cfg_reg.thr) * (SUMV_W+THR_W)'(SENSOR_COUNT);

    localparam int CENTER = (SENSOR_COUNT - 1) * 128;
    logic signed [ERR_W-1:0] err_c;
    logic signed [ERR_W:0]   de_c;
    logic signed [ERR_W-1:0] prev_eff;
    logic signed [INTEG_W+TIME_W:0] integ_c;
    logic signed [INTEG_W-1:0] integ_sat;
    assign err_c    = ERR_W'(CENTER) - ERR_W'(div_q);
    assign prev_eff = known_reg ? prev_reg : err_reg;
    assign de_c     = (ERR_W+1)'(err_reg) - (ERR_W+1)'(prev_eff);
    assign integ_c  = (INTEG_W+TIME_W+1)'(integ_reg)
                    + (INTEG_W+TIME_W+1)'(err_reg) * $signed({1'b0, el_reg});
    always_comb begin
        if (integ_c > (INTEG_W+TIME_W+1)'(64'sd2147483647))
            integ_sat = 32'sh7fffffff;
        else if (integ_c < -(INTEG_W+TIME_W+1)'(64'sd2147483648))
            integ_sat = 32'sh80000000;
        else
            integ_sat = integ_c[INTEG_W-1:0];
    end

    logic [ERR_W:0]     de_mag;
    logic [INTEG_W-1:0] integ_mag;
    assign de_mag    = de_c[ERR_W] ? (ERR_W+1)'(-de_c) : de_c;
    assign integ_mag = integ_reg[INTEG_W-1] ? INTEG_W'(-integ_reg) : integ_reg;
    assign d_num_c   = DIV_W'(cfg_reg.kd) * DIV_W'(de_mag) * DIV_W'(1000);

    // integral term: divide by 1000 as a multiply by the reciprocal, 16 bits per step
    logic [15:0]        recip_chunk;
    logic [DIV_W+15:0]  recip_prod;
    logic [ACC_W-1:0]   acc_next;
    logic [DIV_W-1:0]   i_quo;
    always_comb begin
        unique case (step_reg)
            2'd0:    recip_chunk = RECIP_1000[47:32];
            2'd1:    recip_chunk = RECIP_1000[31:16];
            default: recip_chunk = RECIP_1000[15:0];
        endcase
    end
    assign recip_prod = ix_reg * recip_chunk;
    assign acc_next   = {acc_reg[ACC_W-17:0], 16'd0} + ACC_W'(recip_prod);
    assign i_quo      = DIV_W'(acc_next[ACC_W-1:RECIP_SHIFT]);

    logic signed [U_W-1:0] u_c;
    logic signed [U_W-1:0] hi_c;
    logic signed [U_W-1:0] lo_c;
    logic signed [U_W-1:0] u_cl;
    logic signed [U_W-1:0] maxq;
    logic signed [U_W-1:0] left_q;
    logic signed [U_W-1:0] right_q;
    logic [DUTY_W-1:0]     left_c;
    logic [DUTY_W-1:0]     right_c;

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [U_W-1:0] q);
        logic [DUTY_W-1:0] r;
        if (q <= 0) r = '0;
        else if (q >= U_W'(255 * 65536)) r = '1;
        else r = q[16 +: DUTY_W];
        return r;
    endfunction

    assign u_c  = U_W'(p_reg) + U_W'(d_reg) + U_W'(i_reg);
    assign maxq = $signed({{(U_W-DUTY_W-16){1'b0}}, cfg_reg.max_duty, 16'd0});
    assign hi_c = maxq - $signed({{(U_W-DUTY_W-16){1'b0}}, cfg_reg.bias, 16'd0});
    assign lo_c = -maxq;
    always_comb begin
        priority if (u_c > hi_c) u_cl = hi_c;
        else if (u_c < lo_c)     u_cl = lo_c;
        else                     u_cl = u_c;
        if (u_cl < 0) begin
            right_q = maxq + u_cl;
            left_q  = hi_c;
        end else begin
            right_q = maxq;
            left_q  = hi_c - u_cl;
        end
        left_c  = duty_of(left_q);
        right_c = duty_of(right_q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            run_reg       <= '0;
            prev_reg      <= '0;
            known_reg     <= 1'b0;
            integ_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_err_reg   <= '0;
            out_cross_reg <= 1'b0;
            out_lost_reg  <= 1'b0;
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= {s_sensor_7, s_sensor_6, s_sensor_5, s_sensor_4,
                                      s_sensor_3, s_sensor_2, s_sensor_1, s_sensor_0};
                        el_reg    <= s_elapsed_ms;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    run_reg   <= run_sat;
                    div_a_reg <= DIV_W'({sumw_c, 9'd0}) + DIV_W'(sumv_c);
                    div_b_reg <= DIV_W'({sumv_c, 1'b0});
                    if ((SUMV_W+THR_W)'(sumv_c) > cross_lim && run_sat > cfg_reg.startup) begin
                        cross_reg <= 1'b1;
                        lost_reg  <= 1'b0;
                        err_reg   <= '0;
                        integ_reg <= '0;
                        known_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end else if (sumv_c == '0) begin
                        cross_reg <= 1'b0;
                        lost_reg  <= 1'b1;
                        err_reg   <= '0;
                        integ_reg <= '0;
                        known_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        cross_reg <= 1'b0;
                        lost_reg  <= 1'b0;
                        state_reg <= ST_POS_GO;
                    end
                end
                ST_POS_GO: state_reg <= ST_POS_WAIT;
                ST_POS_WAIT: begin
                    if (div_done) begin
                        err_reg   <= err_c;
                        p_reg     <= DIV_W'($signed({1'b0, cfg_reg.kp})) * DIV_W'(err_c);
                        state_reg <= ST_D_GO;
                    end
                end
                ST_D_GO: begin
                    dneg_reg  <= de_c[ERR_W];
                    prev_reg  <= err_reg;
                    known_reg <= 1'b1;
                    integ_reg <= integ_sat;
                    state_reg <= ST_D_WAIT;
                end
                ST_D_WAIT: begin
                    if (div_done) begin
                        if (el_reg == '0) d_reg <= '0;
                        else d_reg <= dneg_reg ? -$signed(div_q) : $signed(div_q);
                        state_reg <= ST_I_GO;
                    end
                end
                ST_I_GO: begin
                    ix_reg    <= DIV_W'(cfg_reg.ki) * DIV_W'(integ_mag);
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    dneg_reg  <= integ_reg[INTEG_W-1];
                    state_reg <= ST_I_WAIT;
                end
                ST_I_WAIT: begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2) begin
                        i_reg     <= dneg_reg ? -$signed(i_quo) : $signed(i_quo);
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    left_reg  <= left_c;
                    right_reg <= right_c;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_left_reg  <= left_reg;
                        out_right_reg <= right_reg;
                        out_err_reg   <= err_reg;
                        out_cross_reg <= cross_reg;
                        out_lost_reg  <= lost_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_left_duty      = out_left_reg;
    assign m_right_duty     = out_right_reg;
    assign m_position_error = out_err_reg;
    assign m_crossing       = out_cross_reg;
    assign m_line_lost      = out_lost_reg;

    ast_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_crossing && m_line_lost)) else $error("flags both set");
    ast_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_crossing || m_line_lost) |-> m_position_error == '0)
        else $error("error nonzero on cleared item");
    ast_busy_noaccept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    ast_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_POS_WAIT || state_reg == ST_D_WAIT))
        else $error("stray divider done");
endmodule

FILE: test/line_follow_pid_drive_unit_tb.sv
module line_follow_pid_drive_unit_tb;
    import lfpid_pkg::*;

    typedef struct {
        logic [7:0][9:0] samples;
        logic [15:0]     elapsed;
    } reading_t;

    typedef struct {
        logic [7:0]         left;
        logic [7:0]         right;
        logic signed [10:0] err;
        logic               crossing;
        logic               lost;
    } drive_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NONE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [9:0] s_sensor_0 = '0;
    logic [9:0] s_sensor_1 = '0;
    logic [9:0] s_sensor_2 = '0;
    logic [9:0] s_sensor_3 = '0;
    logic [9:0] s_sensor_4 = '0;
    logic [9:0] s_sensor_5 = '0;
    logic [9:0] s_sensor_6 = '0;
    logic [9:0] s_sensor_7 = '0;
    logic [15:0] s_elapsed_ms = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [7:0] m_left_duty, m_right_duty;
    logic signed [10:0] m_position_error;
    logic m_crossing, m_line_lost;

    line_follow_pid_drive_unit u_top (.*);

    always #5 aclk = ~aclk;

    reading_t pending_readings[$];
    drive_t   expected_drives[$];
    int       failures = 0;
    int       send_idle = 0;
    int       recv_idle = 0;
    bit       hold_send = 0;
    int       quiet_cycles = 0;

    // predictor state and configuration
    longint kp, kd, ki, thr, maxd, bias, startup;
    longint prev_err, integral, run_ms, held_left, held_right;
    bit     prev_known;

    function automatic longint saturate_duty(longint q16);
        if (q16 <= 0) return 0;
        if (q16 >= 255 * 65536) return 255;
        return q16 >>> 16;
    endfunction

    function automatic drive_t predict_drive(reading_t rd);
        drive_t  dv;
        longint  sum_v, sum_w, v, pos, err, d, integ, u, hi, lo, lft, rgt;
        sum_v = 0;
        sum_w = 0;
        err = 0;
        for (int i = 0; i < 8; i++) begin
            v = rd.samples[i];
            if (v < thr) v = 0;
            sum_v += v;
            sum_w += v * i;
        end
        run_ms += rd.elapsed;
        if (run_ms > 65535) run_ms = 65535;
        dv.crossing = 0;
        dv.lost = 0;
        if (sum_v > thr * 8 && run_ms > startup) begin
            dv.crossing = 1;
            integral = 0;
            prev_known = 0;
        end else if (sum_v == 0) begin
            dv.lost = 1;
            integral = 0;
            prev_known = 0;
        end else begin
            pos = (512 * sum_w + sum_v) / (2 * sum_v);
            err = 7 * 128 - pos;
            if (!prev_known) prev_err = err;
            d = 0;
            if (rd.elapsed != 0) d = (kd * (err - prev_err) * 1000) / longint'(rd.elapsed);
            prev_err = err;
            prev_known = 1;
            integ = integral + err * longint'(rd.elapsed);
            if (integ > 64'sd2147483647) integ = 64'sd2147483647;
            if (integ < -64'sd2147483648) integ = -64'sd2147483648;
            integral = integ;
            u = kp * err + d + (ki * integ) / 1000;
            hi = (maxd - bias) * 65536;
            lo = -maxd * 65536;
            if (u > hi) u = hi;
            else if (u < lo) u = lo;
            if (u < 0) begin
                rgt = maxd * 65536 + u;
                lft = (maxd - bias) * 65536;
            end else begin
                rgt = maxd * 65536;
                lft = (maxd - bias) * 65536 - u;
            end
            held_left = saturate_duty(lft);
            held_right = saturate_duty(rgt);
        end
        dv.left = held_left[7:0];
        dv.right = held_right[7:0];
        dv.err = err[10:0];
        return dv;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_drives.push_back(predict_drive(pending_readings.pop_front()));
            end
            if (!s_valid || s_ready) begin
                if (pending_readings.size() > (s_valid && s_ready ? 0 : 0) && !hold_send
                        && $urandom_range(99) >= send_idle
                        && !(s_valid && s_ready && pending_readings.size() == 0)) begin
                    s_valid <= 1;
                    s_sensor_0 <= pending_readings[0].samples[0];
                    s_sensor_1 <= pending_readings[0].samples[1];
                    s_sensor_2 <= pending_readings[0].samples[2];
                    s_sensor_3 <= pending_readings[0].samples[3];
                    s_sensor_4 <= pending_readings[0].samples[4];
                    s_sensor_5 <= pending_readings[0].samples[5];
                    s_sensor_6 <= pending_readings[0].samples[6];
                    s_sensor_7 <= pending_readings[0].samples[7];
                    s_elapsed_ms <= pending_readings[0].elapsed;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t: unexpected result left=%0d right=%0d", $time,
                             m_left_duty, m_right_duty);
                    failures++;
                end else begin
                    drive_t e;
                    e = expected_drives.pop_front();
                    if (e.left !== m_left_duty || e.right !== m_right_duty
                            || e.err !== m_position_error || e.crossing !== m_crossing
                            || e.lost !== m_line_lost) begin
                        $display("%0t: expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 $time, e.left, e.right, e.err, e.crossing, e.lost,
                                 m_left_duty, m_right_duty, m_position_error, m_crossing,
                                 m_line_lost);
                        failures++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, longint value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge aclk);
        cfg_we <= 0;
        cfg_index <= REG_NONE;
        case (idx)
            REG_KP: kp = value & 16'hFFFF;
            REG_KD: kd = value & 16'hFFFF;
            REG_KI: ki = value & 16'hFFFF;
            REG_THR: thr = value & 10'h3FF;
            REG_MAX: maxd = value & 8'hFF;
            REG_BIAS: bias = value & 8'hFF;
            REG_STARTUP: startup = value & 16'hFFFF;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_readings.size() != 0 || s_valid || expected_drives.size() != 0)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic queue_reading(logic [7:0][9:0] smp, logic [15:0] el);
        reading_t rd;
        rd.samples = smp;
        rd.elapsed = el;
        pending_readings.push_back(rd);
    endtask

    function automatic logic [7:0][9:0] line_samples(int centre, int width, int lvl);
        logic [7:0][9:0] smp;
        for (int i = 0; i < 8; i++) begin
            if (i >= centre - width && i <= centre + width)
                smp[i] = 10'($urandom_range(1023, lvl));
            else
                smp[i] = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                                  : 10'($urandom_range(lvl));
        end
        return smp;
    endfunction

    task automatic random_phase(int count);
        logic [7:0][9:0] smp;
        logic [15:0] el;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: smp = 80'({$urandom, $urandom, $urandom});
                1: smp = '0;
                2: for (int i = 0; i < 8; i++) smp[i] = 10'($urandom_range(1023, 900));
                default: smp = line_samples($urandom_range(7), $urandom_range(2),
                                            int'(thr));
            endcase
            case ($urandom_range(7))
                0: el = '0;
                1: el = 16'($urandom);
                2: el = 16'hFFFF;
                default: el = 16'($urandom_range(20, 1));
            endcase
            queue_reading(smp, el);
        end
    endtask

    initial begin
        kp = 32000; kd = 3584; ki = 0; thr = 512; maxd = 255; bias = 20; startup = 1000;
        prev_err = 0; prev_known = 0; integral = 0; run_ms = 0;
        held_left = 0; held_right = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_idle = 34;
        recv_idle = 75;
        // directed: extremes, lost line, hard left and right, zero time
        queue_reading('0, 16'd0);
        queue_reading({10'd1023, 70'd0}, 16'd5);
        queue_reading({70'd0, 10'd1023}, 16'd5);
        queue_reading({70'd0, 10'd1023}, 16'd0);
        queue_reading({{3{10'd0}}, 10'd600, 10'd600, {3{10'd0}}}, 16'd1);
        queue_reading({10'd511, 10'd512, {6{10'd0}}}, 16'd3);
        queue_reading({8{10'd1023}}, 16'hFFFF);
        queue_reading({{4{10'd0}}, {4{10'd800}}}, 16'hFFFF);
        queue_reading({8{10'd1023}}, 16'd1);
        queue_reading({{7{10'd0}}, 10'd513}, 16'd7);
        queue_reading({10'd0, 10'd1023, {6{10'd0}}}, 16'd2);
        drain();

        write_reg(REG_KP, 16'hFFFF);
        write_reg(REG_KD, 16'hFFFF);
        write_reg(REG_KI, 16'hFFFF);
        write_reg(REG_THR, 0);
        write_reg(REG_MAX, 1);
        write_reg(REG_BIAS, 255);
        write_reg(REG_STARTUP, 16'hFFFF);
        queue_reading({8{10'h2AA}}, 16'h5555);
        queue_reading({8{10'h155}}, 16'hAAAA);
        random_phase(300);
        drain();

        hold_send = 1;
        drain();
        hold_send = 0;

        send_idle = 75;
        recv_idle = 34;
        write_reg(REG_KP, 256);
        write_reg(REG_KD, 100);
        write_reg(REG_KI, 5000);
        write_reg(REG_THR, 1023);
        write_reg(REG_MAX, 200);
        write_reg(REG_BIAS, 0);
        write_reg(REG_STARTUP, 0);
        random_phase(300);
        drain();

        write_reg(REG_KP, 0);
        write_reg(REG_KD, 0);
        write_reg(REG_KI, 0);
        write_reg(REG_THR, 300);
        write_reg(REG_MAX, 255);
        write_reg(REG_BIAS, 20);
        write_reg(REG_STARTUP, 500);
        random_phase(300);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_KP, $urandom_range(65535));
        write_reg(REG_KD, $urandom_range(65535));
        write_reg(REG_KI, $urandom_range(65535));
        write_reg(REG_THR, $urandom_range(700, 100));
        write_reg(REG_MAX, $urandom_range(255, 1));
        write_reg(REG_BIAS, $urandom_range(255));
        write_reg(REG_STARTUP, $urandom_range(3000));
        random_phase(350);
        drain();

        write_reg(REG_KP, 32000);
        write_reg(REG_KD, 3584);
        write_reg(REG_KI, 40);
        write_reg(REG_THR, 512);
        write_reg(REG_MAX, 255);
        write_reg(REG_BIAS, 20);
        write_reg(REG_STARTUP, 1000);
        random_phase(350);
        drain();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
design/lfpid_pkg.sv
design/lfpid_lane.sv
design/lfpid_div.sv
design/line_follow_pid_drive_unit.sv
test/line_follow_pid_drive_unit_tb.sv
